// ===== hdl/ffsa_pkg.sv =====
// Shared types and constants for the first-fit segment allocator.
// Used by ffsa_table, ffsa_ctrl and first_fit_segment_allocator; no dependencies.
package ffsa_pkg;

  localparam int SEG_DEPTH = 64;
  localparam int IDX_W     = $clog2(SEG_DEPTH);
  localparam int CNT_W     = IDX_W + 1;
  localparam int ADDR_W    = 20;
  localparam int LEN_W     = ADDR_W + 1;
  localparam int STAT_W    = 3;

  localparam logic [LEN_W-1:0] POOL_MAX   = LEN_W'(1) << ADDR_W;
  localparam logic [LEN_W-1:0] POOL_RESET = POOL_MAX;

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  localparam logic [STAT_W-1:0] ST_OK      = 3'd0;
  localparam logic [STAT_W-1:0] ST_NOMEM   = 3'd1;
  localparam logic [STAT_W-1:0] ST_BADADDR = 3'd2;
  localparam logic [STAT_W-1:0] ST_FULL    = 3'd3;
  localparam logic [STAT_W-1:0] ST_ZERO    = 3'd4;

  typedef struct packed {
    logic              req_type;
    logic [LEN_W-1:0]  request_size;
    logic [ADDR_W-1:0] block_address;
  } req_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [ADDR_W-1:0] granted_address;
  } rsp_t;

  typedef struct packed {
    logic [LEN_W-1:0] len;
    logic             free;
  } seg_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    seg_t             data;
  } wr_t;

endpackage

// ===== hdl/ffsa_table.sv =====
// Segment table memory: one write port, one read port with registered read data.
// Depends on ffsa_pkg for the entry and write-port types.
module ffsa_table (
  input  logic                    clk,
  input  ffsa_pkg::wr_t           wr,
  input  logic [ffsa_pkg::IDX_W-1:0] raddr,
  output ffsa_pkg::seg_t          rdata
);

  ffsa_pkg::seg_t mem [ffsa_pkg::SEG_DEPTH];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/ffsa_ctrl.sv =====
// Request sequencer: scans the segment table, splits, merges and shifts entries.
// Depends on ffsa_pkg; drives the ports of ffsa_table.
module ffsa_ctrl (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  ffsa_pkg::req_t              req,
  input  logic                        restore,
  input  logic [ffsa_pkg::LEN_W-1:0]  pool,
  input  ffsa_pkg::seg_t              rdata,
  output logic [ffsa_pkg::IDX_W-1:0]  raddr,
  output ffsa_pkg::wr_t               wr,
  output logic                        busy,
  output logic                        done,
  output ffsa_pkg::rsp_t              rsp
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_INIT  = 7'b0000010,
    S_SCAN  = 7'b0000100,
    S_FNEXT = 7'b0001000,
    S_MVRD  = 7'b0010000,
    S_MOVE  = 7'b0100000,
    S_SPLIT = 7'b1000000
  } state_t;

  state_t                       state, state_next;
  logic [ffsa_pkg::IDX_W-1:0]   idx, idx_next;
  logic [ffsa_pkg::CNT_W-1:0]   cnt, cnt_next;
  logic [ffsa_pkg::LEN_W-1:0]   base, base_next;
  ffsa_pkg::req_t               op, op_next;
  logic [ffsa_pkg::IDX_W-1:0]   fit, fit_next;
  ffsa_pkg::seg_t               cur, cur_next;
  ffsa_pkg::seg_t               prev, prev_next;
  logic [ffsa_pkg::IDX_W-1:0]   src, src_next;
  logic [ffsa_pkg::IDX_W-1:0]   last, last_next;
  logic                         up, up_next;
  logic [1:0]                   span, span_next;
  logic                         done_next;
  ffsa_pkg::rsp_t               rsp_next;

  logic [ffsa_pkg::CNT_W-1:0]   cnt_m1;
  logic                         last_entry;
  logic                         fits;
  logic                         hit;
  logic                         has_next;
  logic                         nf;
  logic                         pf;
  logic [ffsa_pkg::CNT_W-1:0]   s0;

  assign busy       = (state != S_IDLE);
  assign cnt_m1     = cnt - ffsa_pkg::CNT_W'(1);
  assign last_entry = ({1'b0, idx} == cnt_m1);
  assign fits       = rdata.free && (rdata.len >= op.request_size);
  assign hit        = (base == {1'b0, op.block_address});
  assign has_next   = (({1'b0, fit} + ffsa_pkg::CNT_W'(1)) != cnt);
  assign nf         = has_next && rdata.free;
  assign pf         = (fit != '0) && prev.free;

  always_comb begin
    unique case (state)
      S_SCAN:  raddr = idx + ffsa_pkg::IDX_W'(1);
      S_MVRD:  raddr = src;
      S_MOVE:  raddr = up ? (src - ffsa_pkg::IDX_W'(1)) : (src + ffsa_pkg::IDX_W'(1));
      default: raddr = '0;
    endcase
  end

  always_comb begin
    state_next = state;
    idx_next   = idx;
    cnt_next   = cnt;
    base_next  = base;
    op_next    = op;
    fit_next   = fit;
    cur_next   = cur;
    prev_next  = prev;
    src_next   = src;
    last_next  = last;
    up_next    = up;
    span_next  = span;
    done_next  = 1'b0;
    rsp_next   = rsp;
    wr         = '0;
    s0         = '0;

    unique case (state)
      S_IDLE: begin
        if (start) begin
          op_next   = req;
          idx_next  = '0;
          base_next = '0;
          if (req.req_type == ffsa_pkg::REQ_ALLOC && req.request_size == '0) begin
            done_next = 1'b1;
            rsp_next  = '{status: ffsa_pkg::ST_ZERO, granted_address: '0};
          end else begin
            state_next = S_SCAN;
          end
        end
      end

      S_INIT: begin
        wr         = '{en: 1'b1, addr: '0, data: '{len: pool, free: 1'b1}};
        cnt_next   = ffsa_pkg::CNT_W'(1);
        state_next = S_IDLE;
      end

      S_SCAN: begin
        if (op.req_type == ffsa_pkg::REQ_ALLOC) begin
          if (fits) begin
            if (rdata.len == op.request_size) begin
              wr         = '{en: 1'b1, addr: idx, data: '{len: rdata.len, free: 1'b0}};
              done_next  = 1'b1;
              rsp_next   = '{status: ffsa_pkg::ST_OK, granted_address: base[ffsa_pkg::ADDR_W-1:0]};
              state_next = S_IDLE;
            end else if (cnt == ffsa_pkg::CNT_W'(ffsa_pkg::SEG_DEPTH)) begin
              done_next  = 1'b1;
              rsp_next   = '{status: ffsa_pkg::ST_FULL, granted_address: '0};
              state_next = S_IDLE;
            end else begin
              wr        = '{en: 1'b1, addr: idx, data: '{len: op.request_size, free: 1'b0}};
              fit_next  = idx;
              cur_next  = rdata;
              src_next  = cnt_m1[ffsa_pkg::IDX_W-1:0];
              last_next = idx + ffsa_pkg::IDX_W'(1);
              up_next   = 1'b1;
              span_next = 2'd1;
              state_next = last_entry ? S_SPLIT : S_MVRD;
            end
          end else if (last_entry) begin
            done_next  = 1'b1;
            rsp_next   = '{status: ffsa_pkg::ST_NOMEM, granted_address: '0};
            state_next = S_IDLE;
          end else begin
            idx_next  = idx + ffsa_pkg::IDX_W'(1);
            base_next = base + rdata.len;
            prev_next = rdata;
          end
        end else begin
          if (hit) begin
            if (rdata.free) begin
              done_next  = 1'b1;
              rsp_next   = '{status: ffsa_pkg::ST_BADADDR, granted_address: '0};
              state_next = S_IDLE;
            end else begin
              fit_next   = idx;
              cur_next   = rdata;
              state_next = S_FNEXT;
            end
          end else if (last_entry) begin
            done_next  = 1'b1;
            rsp_next   = '{status: ffsa_pkg::ST_BADADDR, granted_address: '0};
            state_next = S_IDLE;
          end else begin
            idx_next  = idx + ffsa_pkg::IDX_W'(1);
            base_next = base + rdata.len;
            prev_next = rdata;
          end
        end
      end

      S_FNEXT: begin
        if (nf && pf) begin
          wr        = '{en: 1'b1, addr: fit - ffsa_pkg::IDX_W'(1),
                        data: '{len: prev.len + cur.len + rdata.len, free: 1'b1}};
          cnt_next  = cnt - ffsa_pkg::CNT_W'(2);
          s0        = {1'b0, fit} + ffsa_pkg::CNT_W'(2);
          span_next = 2'd2;
        end else if (nf) begin
          wr        = '{en: 1'b1, addr: fit, data: '{len: cur.len + rdata.len, free: 1'b1}};
          cnt_next  = cnt_m1;
          s0        = {1'b0, fit} + ffsa_pkg::CNT_W'(2);
          span_next = 2'd1;
        end else if (pf) begin
          wr        = '{en: 1'b1, addr: fit - ffsa_pkg::IDX_W'(1),
                        data: '{len: prev.len + cur.len, free: 1'b1}};
          cnt_next  = cnt_m1;
          s0        = {1'b0, fit} + ffsa_pkg::CNT_W'(1);
          span_next = 2'd1;
        end else begin
          wr = '{en: 1'b1, addr: fit, data: '{len: cur.len, free: 1'b1}};
        end
        src_next  = s0[ffsa_pkg::IDX_W-1:0];
        last_next = cnt_m1[ffsa_pkg::IDX_W-1:0];
        up_next   = 1'b0;
        if ((nf || pf) && (s0 < cnt)) begin
          state_next = S_MVRD;
        end else begin
          done_next  = 1'b1;
          rsp_next   = '{status: ffsa_pkg::ST_OK, granted_address: '0};
          state_next = S_IDLE;
        end
      end

      S_MVRD: begin
        state_next = S_MOVE;
      end

      S_MOVE: begin
        wr = '{en: 1'b1,
               addr: up ? (src + ffsa_pkg::IDX_W'(1)) : (src - ffsa_pkg::IDX_W'(span)),
               data: rdata};
        if (src == last) begin
          if (up) begin
            state_next = S_SPLIT;
          end else begin
            done_next  = 1'b1;
            rsp_next   = '{status: ffsa_pkg::ST_OK, granted_address: '0};
            state_next = S_IDLE;
          end
        end else begin
          src_next = up ? (src - ffsa_pkg::IDX_W'(1)) : (src + ffsa_pkg::IDX_W'(1));
        end
      end

      S_SPLIT: begin
        wr = '{en: 1'b1, addr: fit + ffsa_pkg::IDX_W'(1),
               data: '{len: cur.len - op.request_size, free: 1'b1}};
        cnt_next   = cnt + ffsa_pkg::CNT_W'(1);
        done_next  = 1'b1;
        rsp_next   = '{status: ffsa_pkg::ST_OK, granted_address: base[ffsa_pkg::ADDR_W-1:0]};
        state_next = S_IDLE;
      end

      default: begin
        state_next = S_INIT;
      end
    endcase

    if (restore) begin
      state_next = S_INIT;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
      cnt   <= ffsa_pkg::CNT_W'(1);
      done  <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      done  <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    idx  <= idx_next;
    base <= base_next;
    op   <= op_next;
    fit  <= fit_next;
    cur  <= cur_next;
    prev <= prev_next;
    src  <= src_next;
    last <= last_next;
    up   <= up_next;
    span <= span_next;
    rsp  <= rsp_next;
  end

`ifndef NO_ASSERTIONS
  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    (cnt != '0) && (cnt <= ffsa_pkg::CNT_W'(ffsa_pkg::SEG_DEPTH)))
    else $error("segment count out of range");

  a_accept_progress: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && !restore) |=> (busy || done))
    else $error("accepted request neither in progress nor answered");

  a_error_no_grant: assert property (@(posedge clk) disable iff (rst)
    (done && rsp.status != ffsa_pkg::ST_OK) |-> (rsp.granted_address == '0))
    else $error("error result carries a nonzero offset");

  a_split_room: assert property (@(posedge clk) disable iff (rst)
    (state == S_SPLIT) |-> (cnt < ffsa_pkg::CNT_W'(ffsa_pkg::SEG_DEPTH)))
    else $error("split started on a full table");

  a_idle_no_write: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !wr.en)
    else $error("table written while idle");
`endif

endmodule

// ===== hdl/first_fit_segment_allocator.sv =====
// Top level of the first-fit segment allocator: pool size register, sequencer and table.
// Depends on ffsa_pkg, ffsa_ctrl and ffsa_table.
//
// One request is taken when start is high and busy is low; its single result beat appears
// on rsp with done high for exactly one cycle and cannot be held off. The table lives in
// one memory with a single read port, so a request walks the segments one per cycle; a
// split or merge must also shift the later entries before it answers, and an allocate
// of zero units answers in the cycle after it is taken, without a scan. The scan and the
// shift together never pass more entries than the table holds. After reset and after each
// write of the pool size register the block is busy for one cycle while it rebuilds the
// single free segment.
module first_fit_segment_allocator (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  ffsa_pkg::req_t             req,
  output logic                       busy,
  output logic                       done,
  output ffsa_pkg::rsp_t             rsp,
  input  logic                       cfg_we,
  input  logic [ffsa_pkg::LEN_W-1:0] cfg_wdata
);

  logic [ffsa_pkg::LEN_W-1:0] pool;
  logic [ffsa_pkg::LEN_W-1:0] pool_next;
  logic [ffsa_pkg::IDX_W-1:0] raddr;
  ffsa_pkg::seg_t             rdata;
  ffsa_pkg::wr_t              wr;

  always_comb begin
    if (cfg_wdata == '0) begin
      pool_next = ffsa_pkg::LEN_W'(1);
    end else if (cfg_wdata > ffsa_pkg::POOL_MAX) begin
      pool_next = ffsa_pkg::POOL_MAX;
    end else begin
      pool_next = cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pool <= ffsa_pkg::POOL_RESET;
    end else if (cfg_we) begin
      pool <= pool_next;
    end
  end

  ffsa_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .req     (req),
    .restore (cfg_we),
    .pool    (pool),
    .rdata   (rdata),
    .raddr   (raddr),
    .wr      (wr),
    .busy    (busy),
    .done    (done),
    .rsp     (rsp)
  );

  ffsa_table u_table (
    .clk   (clk),
    .wr    (wr),
    .raddr (raddr),
    .rdata (rdata)
  );

endmodule
